// ===== sv/cpfm_pkg.sv =====
package cpfm_pkg;

    localparam int COUNT_RATE_W  = 28;
    localparam int RELOAD_W      = 16;
    localparam int CAP_FIELD_W   = 16;
    localparam int PERIOD_W      = 32;
    localparam int OVF_W         = 8;
    localparam int PROD_W        = OVF_W + RELOAD_W;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 28;
    localparam int DIV_STEPS     = COUNT_RATE_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam int COUNTER_WIDTH_DEF = 16;

    localparam logic [COUNT_RATE_W-1:0] COUNT_RATE_RST = COUNT_RATE_W'(100000);
    localparam logic [RELOAD_W-1:0]     RELOAD_RST     = RELOAD_W'(65534);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNT_RATE    = 1'b0,
        REG_PERIOD_RELOAD = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ADD  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

endpackage

// ===== sv/capture_period_frequency_meter_top.sv =====
// A second capture beat passes through ST_ADD (period sum), ST_DIV (bit-serial
// restoring division) and ST_HOLD (output load, waiting while m_valid is not taken);
// zero period skips the division. Overflow and first-capture beats stay in ST_IDLE.
// s_ready is low outside ST_IDLE, so no new beat is taken until the result is loaded.
// Reset (aresetn, synchronous, active low) clears control state and the capture
// state and loads count_rate = 100000, period_reload = 65534.
module capture_period_frequency_meter_top #(
    parameter int COUNTER_WIDTH = cpfm_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cpfm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpfm_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [cpfm_pkg::CAP_FIELD_W-1:0]   s_capture_value,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [cpfm_pkg::COUNT_RATE_W-1:0]  m_frequency_hz,
    output logic [cpfm_pkg::PERIOD_W-1:0]      m_period_counts,
    output logic                               m_zero_period
);

    localparam int CAP_W = (COUNTER_WIDTH < cpfm_pkg::CAP_FIELD_W) ?
                           COUNTER_WIDTH : cpfm_pkg::CAP_FIELD_W;
    localparam int PW    = cpfm_pkg::PERIOD_W;
    localparam int CRW   = cpfm_pkg::COUNT_RATE_W;

    logic [CRW-1:0]                      count_rate_reg;
    logic [cpfm_pkg::RELOAD_W-1:0]       reload_reg;
    logic                                first_seen_reg;
    logic [CAP_W-1:0]                    stored_reg;
    logic [cpfm_pkg::OVF_W-1:0]          ovf_reg;

    cpfm_pkg::state_t                    state_reg;
    logic [PW-1:0]                       base_reg;
    logic [PW-1:0]                       corr_reg;
    logic [PW-1:0]                       period_reg;
    logic                                zero_reg;
    logic [PW-1:0]                       rem_reg;
    logic [CRW-1:0]                      dvd_reg;
    logic [cpfm_pkg::DIV_CNT_W-1:0]      cnt_reg;

    logic                                m_valid_reg;
    logic [CRW-1:0]                      m_freq_reg;
    logic [PW-1:0]                       m_period_reg;
    logic                                m_zero_reg;

    logic                                s_fire;
    logic [PW-1:0]                       cap_ext;
    logic [PW-1:0]                       stored_ext;
    logic [PW-1:0]                       reload_ext;
    logic [PW-1:0]                       base_next;
    logic [PW-1:0]                       corr_next;
    logic [cpfm_pkg::PROD_W-1:0]         prod;
    logic [PW-1:0]                       sum;
    logic [PW:0]                         trial;
    logic [PW+1:0]                       diff;
    logic                                qbit;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == cpfm_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;

    assign m_valid         = m_valid_reg;
    assign m_frequency_hz  = m_freq_reg;
    assign m_period_counts = m_period_reg;
    assign m_zero_period   = m_zero_reg;

    assign cap_ext    = PW'(s_capture_value[CAP_W-1:0]);
    assign stored_ext = PW'(stored_reg);
    assign reload_ext = PW'(reload_reg);
    assign prod       = (cpfm_pkg::PROD_W)'(ovf_reg - cpfm_pkg::OVF_W'(2)) *
                        (cpfm_pkg::PROD_W)'(reload_reg);

    always_comb begin
        if (ovf_reg == '0) begin
            base_next = cap_ext - stored_ext;
        end else begin
            base_next = reload_ext - stored_ext + cap_ext;
        end
        if (ovf_reg == cpfm_pkg::OVF_W'(1)) begin
            corr_next = '0 - reload_ext;
        end else if (ovf_reg == '0) begin
            corr_next = '0;
        end else begin
            corr_next = PW'(prod);
        end
    end

    assign sum   = base_reg + corr_reg;
    assign trial = {rem_reg, dvd_reg[CRW-1]};
    assign diff  = {1'b0, trial} - {2'b00, period_reg};
    assign qbit  = ~diff[PW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_rate_reg <= cpfm_pkg::COUNT_RATE_RST;
            reload_reg     <= cpfm_pkg::RELOAD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cpfm_pkg::REG_COUNT_RATE: begin
                    count_rate_reg <= cfg_wdata[CRW-1:0];
                end
                cpfm_pkg::REG_PERIOD_RELOAD: begin
                    reload_reg <= cfg_wdata[cpfm_pkg::RELOAD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cpfm_pkg::ST_IDLE;
            first_seen_reg <= 1'b0;
            stored_reg     <= '0;
            ovf_reg        <= '0;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != cpfm_pkg::ST_HOLD) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                cpfm_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        if (!s_func) begin
                            ovf_reg <= ovf_reg + cpfm_pkg::OVF_W'(1);
                        end else if (!first_seen_reg) begin
                            stored_reg     <= s_capture_value[CAP_W-1:0];
                            first_seen_reg <= 1'b1;
                        end else begin
                            base_reg       <= base_next;
                            corr_reg       <= corr_next;
                            first_seen_reg <= 1'b0;
                            ovf_reg        <= '0;
                            state_reg      <= cpfm_pkg::ST_ADD;
                        end
                    end
                end
                cpfm_pkg::ST_ADD: begin
                    period_reg <= sum;
                    zero_reg   <= (sum == '0);
                    rem_reg    <= '0;
                    cnt_reg    <= '0;
                    if (sum == '0) begin
                        dvd_reg   <= '0;
                        state_reg <= cpfm_pkg::ST_HOLD;
                    end else begin
                        dvd_reg   <= count_rate_reg;
                        state_reg <= cpfm_pkg::ST_DIV;
                    end
                end
                cpfm_pkg::ST_DIV: begin
                    rem_reg <= qbit ? diff[PW-1:0] : trial[PW-1:0];
                    dvd_reg <= {dvd_reg[CRW-2:0], qbit};
                    cnt_reg <= cnt_reg + cpfm_pkg::DIV_CNT_W'(1);
                    if (cnt_reg == cpfm_pkg::DIV_CNT_W'(cpfm_pkg::DIV_STEPS - 1)) begin
                        state_reg <= cpfm_pkg::ST_HOLD;
                    end
                end
                cpfm_pkg::ST_HOLD: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_freq_reg   <= dvd_reg;
                        m_period_reg <= period_reg;
                        m_zero_reg   <= zero_reg;
                        state_reg    <= cpfm_pkg::ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= cpfm_pkg::ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/capture_period_frequency_meter_top_tb.sv =====
`timescale 1ns / 1ps

module capture_period_frequency_meter_top_tb;
    import cpfm_pkg::*;

    localparam int TARGET_BEATS = 1700;
    localparam int PHASE_BEATS  = 150;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 500;

    typedef struct packed {
        logic [COUNT_RATE_W-1:0] freq;
        logic [PERIOD_W-1:0]     period;
        logic                    zero;
    } reading_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_func;
    logic [CAP_FIELD_W-1:0]   s_capture_value;
    logic                     m_valid;
    logic                     m_ready;
    logic [COUNT_RATE_W-1:0]  m_frequency_hz;
    logic [PERIOD_W-1:0]      m_period_counts;
    logic                     m_zero_period;

    // Shadow of the meter's configuration and capture state
    logic [COUNT_RATE_W-1:0]  rate_q;
    logic [RELOAD_W-1:0]      reload_q;
    logic                     armed_q;
    logic [CAP_FIELD_W-1:0]   start_q;
    logic [OVF_W-1:0]         ovf_q;

    reading_t pending_readings[$];

    int  beats_sent;
    int  readings_seen;
    int  zero_seen;
    int  cfg_writes;
    int  mismatches;
    int  cycle_cnt;
    int  hold_left;
    bit  gaps_on;

    capture_period_frequency_meter_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_capture_value (s_capture_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frequency_hz  (m_frequency_hz),
        .m_period_counts (m_period_counts),
        .m_zero_period   (m_zero_period)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d readings outstanding",
                     cycle_cnt, pending_readings.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Update the shadow state for one accepted beat; a second capture yields a reading.
    task automatic apply_beat(input logic func, input logic [CAP_FIELD_W-1:0] cap);
        reading_t            r;
        logic [PERIOD_W-1:0] span;
        logic [PERIOD_W-1:0] corr;
        if (!func) begin
            ovf_q = ovf_q + OVF_W'(1);
        end else if (!armed_q) begin
            start_q = cap;
            armed_q = 1'b1;
        end else begin
            if (ovf_q == '0) begin
                span = PERIOD_W'(cap) - PERIOD_W'(start_q);
            end else begin
                corr = (PERIOD_W'(ovf_q) - PERIOD_W'(2)) * PERIOD_W'(reload_q);
                span = (PERIOD_W'(reload_q) - PERIOD_W'(start_q)) + PERIOD_W'(cap) + corr;
            end
            r.period = span;
            r.zero   = (span == '0);
            r.freq   = r.zero ? '0 : COUNT_RATE_W'(PERIOD_W'(rate_q) / span);
            pending_readings.push_back(r);
            armed_q = 1'b0;
            ovf_q   = '0;
        end
    endtask

    task automatic send_beat(input logic func, input logic [CAP_FIELD_W-1:0] cap);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_func          <= func;
        s_capture_value <= cap;
        do @(posedge aclk); while (!s_ready);
        apply_beat(func, cap);
        beats_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers back to back; caller makes sure the meter is idle.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] rate,
                                input logic [CFG_DATA_W-1:0] reload_word);
        cfg_valid <= 1'b1;
        cfg_index <= REG_COUNT_RATE;
        cfg_wdata <= rate;
        do @(posedge aclk); while (!cfg_ready);
        rate_q = rate[COUNT_RATE_W-1:0];
        cfg_index <= REG_PERIOD_RELOAD;
        cfg_wdata <= reload_word;
        do @(posedge aclk); while (!cfg_ready);
        reload_q = reload_word[RELOAD_W-1:0];
        cfg_valid <= 1'b0;
        cfg_writes += 2;
    endtask

    task automatic measure(input int n_ovf, input logic [CAP_FIELD_W-1:0] cap_a,
                           input logic [CAP_FIELD_W-1:0] cap_b);
        send_beat(1'b1, cap_a);
        repeat (n_ovf) send_beat(1'b0, CAP_FIELD_W'($urandom));
        send_beat(1'b1, cap_b);
    endtask

    task automatic test_reset_defaults();
        measure(0, 16'h0000, 16'hFFFF);
        measure(0, 16'hFFFF, 16'h0000);
        measure(0, 16'd1234, 16'd1234);
        measure(1, 16'd100, 16'd50);
        measure(1, 16'd777, 16'd777);
        measure(2, 16'hFFFF, 16'h0000);
        // overflows before the first capture are carried into the measurement
        repeat (3) send_beat(1'b0, 16'hA5A5);
        measure(0, 16'd10, 16'd20);
        measure(3, 16'd40000, 16'd20000);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        program_regs(28'hFFFFFFF, {12'hFFF, 16'hFFFF});
        measure(0, 16'd0, 16'd1);
        measure(2, 16'd0, 16'hFFFF);
        wait_idle();
        program_regs(28'd1, 28'd1);
        measure(5, 16'd0, 16'd0);
        measure(0, 16'd3, 16'd4);
        wait_idle();
        // count rate and reload of zero are out of range but still defined
        program_regs(28'd0, {12'hABC, 16'h0000});
        measure(0, 16'd5, 16'd9);
        measure(3, 16'd1, 16'd2);
        wait_idle();
        program_regs(28'd200000000, 28'd65535);
        measure(1, 16'd30000, 16'd30);
    endtask

    task automatic test_overflow_wrap();
        measure(255, CAP_FIELD_W'($urandom), CAP_FIELD_W'($urandom));
        measure(256, CAP_FIELD_W'($urandom), CAP_FIELD_W'($urandom));
    endtask

    task automatic test_output_backpressure();
        gaps_on   = 1'b0;
        hold_left = HOLD_CYCLES;
        repeat (12) measure($urandom_range(0, 2), CAP_FIELD_W'($urandom),
                            CAP_FIELD_W'($urandom));
        gaps_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        measure(1, CAP_FIELD_W'($urandom), CAP_FIELD_W'($urandom));
        send_beat(1'b1, CAP_FIELD_W'($urandom));
        wait_idle();
        send_beat(1'b0, CAP_FIELD_W'($urandom));
        wait_idle();
        send_beat(1'b1, CAP_FIELD_W'($urandom));
        wait_idle();
    endtask

    task automatic random_sequence();
        logic [CAP_FIELD_W-1:0] a;
        logic [CAP_FIELD_W-1:0] b;
        int                     n;
        int                     r;
        a = CAP_FIELD_W'($urandom);
        r = $urandom_range(0, 9);
        if (r < 1) b = a;
        else if (r < 3) b = a + CAP_FIELD_W'($urandom_range(0, 15));
        else b = CAP_FIELD_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 40) n = 0;
        else if (r < 60) n = 1;
        else if (r < 80) n = 2;
        else if (r < 95) n = $urandom_range(3, 8);
        else n = $urandom_range(9, 40);
        if ($urandom_range(0, 9) < 8) begin
            measure(n, a, b);
        end else begin
            repeat ($urandom_range(1, 4)) send_beat(1'($urandom), CAP_FIELD_W'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        int                    phase_end;
        logic [CFG_DATA_W-1:0] rate;
        logic [CFG_DATA_W-1:0] reload_word;
        while (beats_sent < TARGET_BEATS) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0: begin
                    rate        = $urandom_range(0, 1) ? 28'hFFFFFFF : 28'd1;
                    reload_word = $urandom_range(0, 1) ? 28'd65535 : 28'd1;
                end
                1: begin
                    rate        = CFG_DATA_W'($urandom_range(1, 5000));
                    reload_word = CFG_DATA_W'($urandom_range(1, 300));
                end
                2: begin
                    rate        = CFG_DATA_W'($urandom);
                    reload_word = CFG_DATA_W'($urandom);
                end
                default: begin
                    rate        = CFG_DATA_W'($urandom_range(1, 200000000));
                    reload_word = CFG_DATA_W'($urandom_range(1, 65535));
                end
            endcase
            program_regs(rate, reload_word);
            gaps_on   = ($urandom_range(0, 3) != 0);
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) random_sequence();
            gaps_on = 1'b1;
        end
    endtask

    initial begin : sink_ctrl
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : check_readings
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected reading freq %0d period %0d zero %0b",
                             $realtime, m_frequency_hz, m_period_counts, m_zero_period);
            end else begin
                want = pending_readings.pop_front();
                readings_seen++;
                if (want.zero) zero_seen++;
                if (m_frequency_hz !== want.freq || m_period_counts !== want.period ||
                    m_zero_period !== want.zero) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mismatch exp freq %0d period %0d zero %0b, got %0d %0d %0b",
                                 $realtime, want.freq, want.period, want.zero,
                                 m_frequency_hz, m_period_counts, m_zero_period);
                end
            end
        end
    end

    initial begin
        aresetn         <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= REG_COUNT_RATE;
        cfg_wdata       <= '0;
        s_valid         <= 1'b0;
        s_func          <= 1'b0;
        s_capture_value <= '0;
        rate_q          = COUNT_RATE_RST;
        reload_q        = RELOAD_RST;
        armed_q         = 1'b0;
        start_q         = '0;
        ovf_q           = '0;
        beats_sent      = 0;
        readings_seen   = 0;
        zero_seen       = 0;
        cfg_writes      = 0;
        mismatches      = 0;
        cycle_cnt       = 0;
        hold_left       = 0;
        gaps_on         = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_overflow_wrap();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();
        wait_idle();

        $display("Ran %0d event beats and checked %0d frequency readings (%0d zero period).",
                 beats_sent, readings_seen, zero_seen);
        $display("Used %0d register writes across default, extreme and random rate/reload.",
                 cfg_writes);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
